>>> hdl/mste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mste_pkg
// Shared types, register indexes and the letter pattern table of the
// Morse symbol timing encoder.
// ----------------------------------------------------------------------------
package mste_pkg;

  localparam int unsigned DurW   = 16;
  localparam int unsigned CharW  = 8;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned SymW   = 4;   // at most four symbols per letter
  localparam int unsigned LenW   = 3;   // holds 0..4
  localparam int unsigned SegW   = 4;   // segment counter, holds 0..8

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDotMs       = 8'd0;
  localparam logic [CfgIdxW-1:0] RegDashMs      = 8'd1;
  localparam logic [CfgIdxW-1:0] RegLetterGapMs = 8'd2;
  localparam logic [CfgIdxW-1:0] RegWordGapMs   = 8'd3;

  // reset values of the timing registers
  localparam logic [DurW-1:0] DotMsReset       = 16'd200;
  localparam logic [DurW-1:0] DashMsReset      = 16'd600;
  localparam logic [DurW-1:0] LetterGapMsReset = 16'd600;
  localparam logic [DurW-1:0] WordGapMsReset   = 16'd1200;

  localparam logic [CharW-1:0] CharSpace = 8'h20;

  // symbol pattern, first symbol in the msb, 1 = dash
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SymW-1:0] pat;
  } sym_t;

  // letter lookup; unmapped bytes give no symbols
  function automatic sym_t sym_lookup(input logic [CharW-1:0] c);
    sym_t s;
    begin
      s = '{len: 3'd0, pat: 4'b0000};
      case (c)
        "O":     s = '{len: 3'd3, pat: 4'b1110};  // - - -
        "L":     s = '{len: 3'd4, pat: 4'b0100};  // . - . .
        "A":     s = '{len: 3'd2, pat: 4'b0100};  // . -
        "M":     s = '{len: 3'd2, pat: 4'b1100};  // - -
        "U":     s = '{len: 3'd3, pat: 4'b0010};  // . . -
        "N":     s = '{len: 3'd2, pat: 4'b1000};  // - .
        "D":     s = '{len: 3'd3, pat: 4'b1000};  // - . .
        "I":     s = '{len: 3'd2, pat: 4'b0000};  // . .
        "P":     s = '{len: 3'd4, pat: 4'b0110};  // . - - .
        default: s = '{len: 3'd0, pat: 4'b0000};
      endcase
      return s;
    end
  endfunction

endpackage

>>> hdl/morse_symbol_timing_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_symbol_timing_encoder
// Turns one message character into a run of timed light segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / character_i) takes one byte per
//   item. Output channel (out_valid_o / out_ready_i) gives one segment per
//   item: light level, duration in ms and a flag on the final segment of
//   the character. A space gives one word-gap segment, a mapped letter gives
//   an on/off pair per dot or dash and then a letter-gap segment, any other
//   byte gives the letter-gap segment alone.
//   Timing: an accepted character is registered in the item stage, and each
//   segment then goes through the output register. A character gives 1 to 9
//   segments (2*symbols+1), one segment per cycle unless the receiver stalls.
//   The next character is accepted in the same cycle as the final segment of
//   the current one is loaded, so characters follow back to back.
//   When the receiver stalls, the output register holds its segment and the
//   segment counter stops; no segment is lost. Reset empties both stages and
//   loads the default timing (200/600/600/1200 ms). The timing registers take
//   writes on cfg_we_i / cfg_index_i / cfg_data_i, to be made by the user only
//   while idle; the block does not enforce it. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
module morse_symbol_timing_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // character input
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mste_pkg::CharW-1:0]       character_i,
  // segment output
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             light_on_o,
  output logic [mste_pkg::DurW-1:0]        segment_len_o,
  output logic                             last_segment_o,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [mste_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mste_pkg::DurW-1:0]        cfg_data_i
);

  // timing registers
  logic [mste_pkg::DurW-1:0] dot_ms_q, dash_ms_q, letter_gap_ms_q, word_gap_ms_q;

  // item stage
  logic                        busy_q, busy_d;
  logic                        space_q, space_d;
  mste_pkg::sym_t              sym_q, sym_d;
  logic [mste_pkg::SegW-1:0]   seg_q, seg_d;

  // output stage
  logic                        out_valid_q, out_valid_d;
  logic                        light_on_q, light_on_d;
  logic [mste_pkg::DurW-1:0]   duration_q, duration_d;
  logic                        last_q, last_d;

  logic                        load;
  logic                        in_accept;
  logic                        seg_on;
  logic                        seg_last;
  logic [mste_pkg::DurW-1:0]   seg_dur;
  logic [mste_pkg::SegW-1:0]   sym_segs;
  logic [1:0]                  sym_idx;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_ms_q        <= mste_pkg::DotMsReset;
      dash_ms_q       <= mste_pkg::DashMsReset;
      letter_gap_ms_q <= mste_pkg::LetterGapMsReset;
      word_gap_ms_q   <= mste_pkg::WordGapMsReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mste_pkg::RegDotMs:       dot_ms_q        <= cfg_data_i;
        mste_pkg::RegDashMs:      dash_ms_q       <= cfg_data_i;
        mste_pkg::RegLetterGapMs: letter_gap_ms_q <= cfg_data_i;
        mste_pkg::RegWordGapMs:   word_gap_ms_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // current segment of the item in flight
  always_comb begin
    sym_segs = {sym_q.len, 1'b0};
    sym_idx  = seg_q[2:1];
    seg_on   = 1'b0;
    seg_last = 1'b0;
    seg_dur  = letter_gap_ms_q;
    if (space_q) begin
      seg_dur  = word_gap_ms_q;
      seg_last = 1'b1;
    end else if (seg_q < sym_segs) begin
      if (!seg_q[0]) begin
        seg_on  = 1'b1;
        seg_dur = sym_q.pat[2'd3 - sym_idx] ? dash_ms_q : dot_ms_q;
      end else begin
        seg_dur = dot_ms_q;
      end
    end else begin
      seg_last = 1'b1;
    end
  end

  // handshake
  assign load       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || (load && seg_last);
  assign in_accept  = in_valid_i && in_ready_o;

  // item stage next state
  always_comb begin
    busy_d  = busy_q;
    space_d = space_q;
    sym_d   = sym_q;
    seg_d   = seg_q;
    if (load) begin
      seg_d = seg_q + 4'd1;
      if (seg_last) begin
        busy_d = 1'b0;
      end
    end
    if (in_accept) begin
      busy_d  = 1'b1;
      space_d = (character_i == mste_pkg::CharSpace);
      sym_d   = mste_pkg::sym_lookup(character_i);
      seg_d   = '0;
    end
  end

  // output stage next state
  always_comb begin
    out_valid_d = out_valid_q;
    light_on_d  = light_on_q;
    duration_d  = duration_q;
    last_d      = last_q;
    if (load) begin
      out_valid_d = 1'b1;
      light_on_d  = seg_on;
      duration_d  = seg_dur;
      last_d      = seg_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    space_q    <= space_d;
    sym_q      <= sym_d;
    seg_q      <= seg_d;
    light_on_q <= light_on_d;
    duration_q <= duration_d;
    last_q     <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign light_on_o     = light_on_q;
  assign segment_len_o  = duration_q;
  assign last_segment_o = last_q;

  // segment counter never runs past the closing gap
  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !space_q |-> seg_q <= sym_segs)
    else $error("segment counter out of range");

  // an accepted item is in flight in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q && seg_q == '0)
    else $error("accepted item not loaded");

  // the closing segment of a character is always an off segment
  a_last_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_segment_o |-> !light_on_o)
    else $error("final segment has light on");

  // a space finishes in a single segment
  a_space_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && space_q |-> seg_last && seg_q == '0)
    else $error("space item emits more than one segment");

  // a loaded segment appears on the output in the next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && last_segment_o == $past(seg_last))
    else $error("segment not presented after load");

endmodule

>>> sim/tb_morse_symbol_timing_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_symbol_timing_encoder
// Self-checking bench for the Morse timing encoder. A short directed list of
// characters runs first at reset timing: a space, unmapped bytes, byte zero,
// lowercase and every mapped letter. Random traffic follows under several
// timing settings, zero and full-scale among them. Both channels stall at
// random except in one setting. Every segment is checked by a local predictor.
// ----------------------------------------------------------------------------
module tb_morse_symbol_timing_encoder;

  localparam int unsigned StallPct       = 34;
  localparam int unsigned RandPerSetting = 72;
  localparam int unsigned NumSettings    = 5;
  localparam int unsigned DrainCycles    = 16;
  // far above any legal stall run on the output side
  localparam int unsigned IdleLimit      = 5000;
  localparam logic [mste_pkg::CfgIdxW-1:0] FirstUnusedIdx = mste_pkg::RegWordGapMs + 8'd1;

  typedef struct packed {
    logic                      light_on;
    logic [mste_pkg::DurW-1:0] segment_len;
    logic                      last_segment;
  } segment_t;

  typedef struct packed {
    logic [mste_pkg::CharW-1:0] ch;
    logic                       typed;   // single gap segment written out by hand
    logic [mste_pkg::DurW-1:0]  gap_ms;
  } plan_row_t;

  // directed characters, run at reset timing
  localparam int unsigned PlanLen = 15;
  localparam plan_row_t DirectedPlan [PlanLen] = '{
    '{8'h20, 1'b1, 16'd1200},  // space gives the word gap
    '{8'h00, 1'b1, 16'd600},   // byte zero, unmapped
    '{8'hFF, 1'b1, 16'd600},   // all ones, unmapped
    '{"a",   1'b1, 16'd600},   // lowercase is not mapped
    '{"p",   1'b1, 16'd600},
    '{"Z",   1'b1, 16'd600},   // uppercase outside the letter set
    '{"O",   1'b0, 16'd0},
    '{"L",   1'b0, 16'd0},
    '{"A",   1'b0, 16'd0},
    '{"M",   1'b0, 16'd0},
    '{"U",   1'b0, 16'd0},
    '{"N",   1'b0, 16'd0},
    '{"D",   1'b0, 16'd0},
    '{"I",   1'b0, 16'd0},
    '{"P",   1'b0, 16'd0}
  };

  localparam logic [mste_pkg::CharW-1:0] MappedLetters [9] = '{
    "O", "L", "A", "M", "U", "N", "D", "I", "P"
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [mste_pkg::CharW-1:0]    character_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic                          light_on_o;
  logic [mste_pkg::DurW-1:0]     segment_len_o;
  logic                          last_segment_o;
  logic                          cfg_we_i    = 1'b0;
  logic [mste_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mste_pkg::DurW-1:0]     cfg_data_i  = '0;

  // predictor copy of the timing registers
  logic [mste_pkg::DurW-1:0] dot_len    = mste_pkg::DotMsReset;
  logic [mste_pkg::DurW-1:0] dash_len   = mste_pkg::DashMsReset;
  logic [mste_pkg::DurW-1:0] letter_gap = mste_pkg::LetterGapMsReset;
  logic [mste_pkg::DurW-1:0] word_gap   = mste_pkg::WordGapMsReset;

  segment_t    pending_segs[$];
  int unsigned err_cnt     = 0;
  int unsigned chars_sent  = 0;
  int unsigned segs_seen   = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_run   = 1'b0;

  morse_symbol_timing_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_i    (character_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .light_on_o     (light_on_o),
    .segment_len_o  (segment_len_o),
    .last_segment_o (last_segment_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // dot/dash spelling of each mapped letter, empty for anything else
  function automatic string morse_of(input logic [mste_pkg::CharW-1:0] c);
    case (c)
      "O":     return "---";
      "L":     return ".-..";
      "A":     return ".-";
      "M":     return "--";
      "U":     return "..-";
      "N":     return "-.";
      "D":     return "-..";
      "I":     return "..";
      "P":     return ".--.";
      default: return "";
    endcase
  endfunction

  // expected segments of one character, appended in order
  function automatic void queue_segments_for(input logic [mste_pkg::CharW-1:0] c);
    string code;
    code = morse_of(c);
    if (c == mste_pkg::CharSpace) begin
      pending_segs.push_back(segment_t'{1'b0, word_gap, 1'b1});
      return;
    end
    for (int s = 0; s < code.len(); s++) begin
      pending_segs.push_back(segment_t'{1'b1, (code[s] == "-") ? dash_len : dot_len, 1'b0});
      pending_segs.push_back(segment_t'{1'b0, dot_len, 1'b0});
    end
    pending_segs.push_back(segment_t'{1'b0, letter_gap, 1'b1});
  endfunction

  // mostly mapped letters, some spaces, the rest any byte
  function automatic logic [mste_pkg::CharW-1:0] random_char();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return MappedLetters[$urandom_range(0, 8)];
    if (pick < 75) return mste_pkg::CharSpace;
    return mste_pkg::CharW'($urandom_range(0, 255));
  endfunction

  // one register write, predictor follows at the write edge
  task automatic write_reg(input logic [mste_pkg::CfgIdxW-1:0] idx,
                           input logic [mste_pkg::DurW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      mste_pkg::RegDotMs:       dot_len    = val;
      mste_pkg::RegDashMs:      dash_len   = val;
      mste_pkg::RegLetterGapMs: letter_gap = val;
      mste_pkg::RegWordGapMs:   word_gap   = val;
      default: ;  // unknown index, write is dropped
    endcase
  endtask

  // full timing setting plus one write to an unused index
  task automatic set_timing(input logic [mste_pkg::DurW-1:0] dot,
                            input logic [mste_pkg::DurW-1:0] dash,
                            input logic [mste_pkg::DurW-1:0] lgap,
                            input logic [mste_pkg::DurW-1:0] wgap);
    write_reg(mste_pkg::RegDotMs, dot);
    write_reg(mste_pkg::RegDashMs, dash);
    write_reg(mste_pkg::RegLetterGapMs, lgap);
    write_reg(mste_pkg::RegWordGapMs, wgap);
    write_reg(mste_pkg::CfgIdxW'($urandom_range(FirstUnusedIdx, 255)),
              mste_pkg::DurW'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // send one character item; starts and ends on a falling edge
  task automatic send_char(input logic [mste_pkg::CharW-1:0] c, input logic typed,
                           input logic [mste_pkg::DurW-1:0] gap);
    while (!quiet_run && $urandom_range(0, 99) < StallPct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
    if (typed) pending_segs.push_back(segment_t'{1'b0, gap, 1'b1});
    else queue_segments_for(c);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= quiet_run || ($urandom_range(0, 99) >= StallPct);
  end

  // segment checker
  always @(posedge clk_i) begin
    segment_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      segs_seen++;
      if (pending_segs.size() == 0) begin
        $error("segment with no character pending: light_on %0b segment_len %0d last %0b",
               light_on_o, segment_len_o, last_segment_o);
        err_cnt++;
      end else begin
        want = pending_segs.pop_front();
        if (light_on_o !== want.light_on) begin
          $error("light_on: expected %0b, actual %0b", want.light_on, light_on_o);
          err_cnt++;
        end
        if (segment_len_o !== want.segment_len) begin
          $error("segment_len: expected %0d, actual %0d", want.segment_len, segment_len_o);
          err_cnt++;
        end
        if (last_segment_o !== want.last_segment) begin
          $error("last_segment: expected %0b, actual %0b", want.last_segment, last_segment_o);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed list at reset timing
    for (int r = 0; r < PlanLen; r++) begin
      send_char(DirectedPlan[r].ch, DirectedPlan[r].typed, DirectedPlan[r].gap_ms);
    end

    // random traffic per timing setting; setting 2 runs without stalls
    for (int p = 0; p < NumSettings; p++) begin
      quiet_run = (p == 2);
      case (p)
        0: ;  // keep reset timing
        1: set_timing(16'd1, 16'd1, 16'd0, 16'd0);
        2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_timing(mste_pkg::DurW'($urandom_range(1, 65535)),
                            mste_pkg::DurW'($urandom_range(1, 65535)),
                            mste_pkg::DurW'($urandom_range(0, 65535)),
                            mste_pkg::DurW'($urandom_range(0, 65535)));
      endcase
      repeat (RandPerSetting) send_char(random_char(), 1'b0, '0);
      in_valid_i <= 1'b0;
      while (pending_segs.size() != 0) @(posedge clk_i);
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d characters: spaces, unmapped and lowercase bytes, every mapped letter",
             chars_sent);
    $display("checked %0d segments over %0d timing settings incl. zero and full-scale",
             segs_seen, NumSettings);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
